[design/hnbc_pkg.sv]
// hnbc_pkg: shared types and codes for the hamming nibble/byte codec
// used by the channel interfaces, the nibble lanes, the merge stage and the top level
package hnbc_pkg;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // syndrome values that name a data bit of the codeword
   localparam logic [2:0] SYN_BIT_A = 3'd3;
   localparam logic [2:0] SYN_BIT_B = 3'd5;
   localparam logic [2:0] SYN_BIT_C = 3'd6;
   localparam logic [2:0] SYN_BIT_D = 3'd7;

   typedef logic [3:0] nibble_type;
   typedef logic [7:0] byte_type;

   // what one lane finds for its nibble, both directions at once
   typedef struct packed {
      byte_type   code;
      nibble_type data;
      logic       fixed;
   } lane_res_type;

endpackage

[design/hnbc_if.sv]
// request and response channels of the hamming nibble/byte codec
// depends on hnbc_pkg for the payload types
interface hnbc_req_if;
   logic                valid;
   logic                ready;
   logic                operation;
   hnbc_pkg::byte_type  data_in;
   hnbc_pkg::byte_type  code_low_in;
   hnbc_pkg::byte_type  code_high_in;

   modport source (output valid, output operation, output data_in,
                   output code_low_in, output code_high_in, input ready);
   modport sink   (input valid, input operation, input data_in,
                   input code_low_in, input code_high_in, output ready);
endinterface

interface hnbc_rsp_if;
   logic                valid;
   logic                ready;
   hnbc_pkg::byte_type  data_out;
   hnbc_pkg::byte_type  code_low_out;
   hnbc_pkg::byte_type  code_high_out;
   logic                fixed_low;
   logic                fixed_high;

   modport source (output valid, output data_out, output code_low_out,
                   output code_high_out, output fixed_low, output fixed_high,
                   input ready);
   modport sink   (input valid, input data_out, input code_low_out,
                   input code_high_out, input fixed_low, input fixed_high,
                   output ready);
endinterface

[design/hamming_nibble_byte_codec_core.sv]
// hamming_nibble_byte_codec_core: byte codec, two nibble lanes and a merge register
// depends on hnbc_pkg, hnbc_if, hnbc_lane and hnbc_merge
// response: in the single output register, valid the cycle after acceptance
// throughput: one word per cycle unless stalled; the register frees when taken
// reset: synchronous active high, clears the response valid only; no other state
module hamming_nibble_byte_codec_core (
   input  logic       clock,
   input  logic       reset,
   hnbc_req_if.sink   req_chan,
   hnbc_rsp_if.source rsp_chan
);

   hnbc_pkg::lane_res_type lane_low, lane_high;

   hnbc_lane u_lane_low (
      .nibble (req_chan.data_in[3:0]),
      .code   (req_chan.code_low_in),
      .res    (lane_low)
   );

   hnbc_lane u_lane_high (
      .nibble (req_chan.data_in[7:4]),
      .code   (req_chan.code_high_in),
      .res    (lane_high)
   );

   hnbc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .operation (req_chan.operation),
      .lane_low  (lane_low),
      .lane_high (lane_high),
      .rsp       (rsp_chan)
   );

endmodule

[design/hnbc_lane.sv]
// hnbc_lane: one nibble lane, hamming(7,4) plus bit 0 parity encode and
// single-error correcting decode; depends on hnbc_pkg
module hnbc_lane (
   input  hnbc_pkg::nibble_type   nibble,
   input  hnbc_pkg::byte_type     code,
   output hnbc_pkg::lane_res_type res
);

   logic       a, b, c, d;
   logic       ra, rb, rc, rd;
   logic [2:0] syndrome;
   logic       fix;

   assign a = nibble[0];
   assign b = nibble[1];
   assign c = nibble[2];
   assign d = nibble[3];

   // received data bits sit at 3, 5, 6, 7; bit 0 is never checked
   assign ra = code[3];
   assign rb = code[5];
   assign rc = code[6];
   assign rd = code[7];

   assign syndrome = {code[4] ^ rb ^ rc ^ rd,
                      code[2] ^ ra ^ rc ^ rd,
                      code[1] ^ ra ^ rb ^ rd};

   always_comb begin
      res.code = {d, c, b, b ^ c ^ d, a, a ^ c ^ d, a ^ b ^ d, a ^ b ^ c};
      res.data = {rd, rc, rb, ra};
      fix      = 1'b1;
      unique case (syndrome)
         hnbc_pkg::SYN_BIT_A: res.data[0] = ~ra;
         hnbc_pkg::SYN_BIT_B: res.data[1] = ~rb;
         hnbc_pkg::SYN_BIT_C: res.data[2] = ~rc;
         hnbc_pkg::SYN_BIT_D: res.data[3] = ~rd;
         default:             fix         = 1'b0;
      endcase
      res.fixed = fix;
   end

endmodule

[design/hnbc_merge.sv]
// hnbc_merge: combines the two lane results into one response word and
// holds it in the output register; depends on hnbc_pkg and hnbc_rsp_if
module hnbc_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  operation,
   input  hnbc_pkg::lane_res_type lane_low,
   input  hnbc_pkg::lane_res_type lane_high,
   hnbc_rsp_if.source            rsp
);

   logic               valid_ff, valid_in;
   logic               load;
   hnbc_pkg::byte_type data_ff, data_in;
   hnbc_pkg::byte_type code_low_ff, code_low_in;
   hnbc_pkg::byte_type code_high_ff, code_high_in;
   logic               fixed_low_ff, fixed_low_in;
   logic               fixed_high_ff, fixed_high_in;

   // output register frees up in the same cycle it is taken
   assign in_ready = ~valid_ff | rsp.ready;
   assign load     = in_valid & in_ready;

   always_comb begin
      valid_in = load | (valid_ff & ~rsp.ready);
      if (operation == hnbc_pkg::OP_DECODE) begin
         data_in       = {lane_high.data, lane_low.data};
         code_low_in   = '0;
         code_high_in  = '0;
         fixed_low_in  = lane_low.fixed;
         fixed_high_in = lane_high.fixed;
      end else begin
         data_in       = '0;
         code_low_in   = lane_low.code;
         code_high_in  = lane_high.code;
         fixed_low_in  = 1'b0;
         fixed_high_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff       <= data_in;
         code_low_ff   <= code_low_in;
         code_high_ff  <= code_high_in;
         fixed_low_ff  <= fixed_low_in;
         fixed_high_ff <= fixed_high_in;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.data_out      = data_ff;
   assign rsp.code_low_out  = code_low_ff;
   assign rsp.code_high_out = code_high_ff;
   assign rsp.fixed_low     = fixed_low_ff;
   assign rsp.fixed_high    = fixed_high_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("accepted word not presented");

   a_encode_clean: assert property (@(posedge clock) disable iff (reset)
      load && operation == hnbc_pkg::OP_ENCODE |=>
         data_ff == '0 && !fixed_low_ff && !fixed_high_ff)
      else $error("encode word carries decode fields");

   a_decode_clean: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (fixed_low_ff || fixed_high_ff) |->
         code_low_ff == '0 && code_high_ff == '0)
      else $error("corrected word carries codewords");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp.ready |=> !$past(load) && $stable(data_ff))
      else $error("stalled word overwritten");

endmodule

[tb/hnbc_scoreboard_pkg.sv]
// scoreboard for the hamming nibble/byte codec testbench: expected response words
// depends on hnbc_pkg for the byte, nibble and operation definitions
package hnbc_scoreboard_pkg;
   import hnbc_pkg::*;

   typedef struct packed {
      byte_type data;
      byte_type code_low;
      byte_type code_high;
      logic     fixed_low;
      logic     fixed_high;
   } codec_word_type;

   // layout: p0 p1 p2 a p4 b c d from bit 0 up
   function automatic byte_type codeword_of(nibble_type n);
      logic a, b, c, d;
      a = n[0];
      b = n[1];
      c = n[2];
      d = n[3];
      return {d, c, b, b ^ c ^ d, a, a ^ c ^ d, a ^ b ^ d, a ^ b ^ c};
   endfunction

   // bit 0 of the received word never takes part
   function automatic nibble_type corrected_nibble(byte_type w, output logic flipped);
      logic [2:0] syndrome;
      logic       a, b, c, d;
      a = w[3];
      b = w[5];
      c = w[6];
      d = w[7];
      syndrome = {w[4] ^ b ^ c ^ d, w[2] ^ a ^ c ^ d, w[1] ^ a ^ b ^ d};
      flipped = 1'b1;
      case (syndrome)
         SYN_BIT_A: a = ~a;
         SYN_BIT_B: b = ~b;
         SYN_BIT_C: c = ~c;
         SYN_BIT_D: d = ~d;
         default: flipped = 1'b0;
      endcase
      return {d, c, b, a};
   endfunction

   class codec_scoreboard;
      codec_word_type expected_q[$];
      int unsigned    errors;

      function void note_request(logic op, byte_type data_in, byte_type code_low_in,
                                 byte_type code_high_in);
         codec_word_type w;
         nibble_type     lo, hi;
         logic           fl, fh;
         w = '0;
         if (op == OP_ENCODE) begin
            w.code_low  = codeword_of(data_in[3:0]);
            w.code_high = codeword_of(data_in[7:4]);
         end else begin
            lo = corrected_nibble(code_low_in, fl);
            hi = corrected_nibble(code_high_in, fh);
            w.data       = {hi, lo};
            w.fixed_low  = fl;
            w.fixed_high = fh;
         end
         expected_q.push_back(w);
      endfunction

      function void check_response(codec_word_type got);
         codec_word_type want;
         if (expected_q.size() == 0) begin
            $error("response word with nothing expected: %h", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.data !== want.data) begin
            $error("data_out: expected %h, got %h", want.data, got.data);
            errors++;
         end
         if (got.code_low !== want.code_low) begin
            $error("code_low_out: expected %h, got %h", want.code_low, got.code_low);
            errors++;
         end
         if (got.code_high !== want.code_high) begin
            $error("code_high_out: expected %h, got %h", want.code_high, got.code_high);
            errors++;
         end
         if (got.fixed_low !== want.fixed_low) begin
            $error("fixed_low: expected %b, got %b", want.fixed_low, got.fixed_low);
            errors++;
         end
         if (got.fixed_high !== want.fixed_high) begin
            $error("fixed_high: expected %b, got %b", want.fixed_high, got.fixed_high);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

[tb/hamming_nibble_byte_codec_core_test.sv]
// top of the hamming nibble/byte codec testbench: clock, reset, stimulus and monitors
// depends on hnbc_pkg, hnbc_if, hnbc_scoreboard_pkg and the codec core
module hamming_nibble_byte_codec_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hnbc_pkg::*;
   import hnbc_scoreboard_pkg::*;

   localparam int RANDOM_WORDS = 1200;
   localparam int STUCK_LIMIT  = 2000;

   logic            clock;
   logic            reset;
   logic            calm;
   int unsigned     stuck_cycles;
   codec_scoreboard codec_sb;

   hnbc_req_if req_chan ();
   hnbc_rsp_if rsp_chan ();

   hamming_nibble_byte_codec_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver stalls about 9 times in a hundred outside the calm stretch
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= calm || ($urandom_range(99) >= 9);
   end

   // monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (req_chan.valid && req_chan.ready)
         codec_sb.note_request(req_chan.operation, req_chan.data_in,
                               req_chan.code_low_in, req_chan.code_high_in);
      if (rsp_chan.valid && rsp_chan.ready)
         codec_sb.check_response({rsp_chan.data_out, rsp_chan.code_low_out,
                                  rsp_chan.code_high_out, rsp_chan.fixed_low,
                                  rsp_chan.fixed_high});
      if (reset)
         stuck_cycles <= 0;
      else if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_word(input logic op, input byte_type data_in,
                            input byte_type code_low_in, input byte_type code_high_in);
      while (!calm && $urandom_range(99) < 9) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.data_in      <= data_in;
      req_chan.code_low_in  <= code_low_in;
      req_chan.code_high_in <= code_high_in;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // sender holds off until every response has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (codec_sb.pending() != 0) @(posedge clock);
   endtask

   // mostly clean or single-error words, some double errors and raw noise
   function automatic byte_type damaged_codeword(nibble_type n);
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick <= 2)
         return codeword_of(n);
      else if (pick <= 6)
         return codeword_of(n) ^ (8'h01 << $urandom_range(7));
      else if (pick <= 8)
         return codeword_of(n) ^ (8'h01 << $urandom_range(7)) ^ (8'h01 << $urandom_range(7));
      else
         return byte_type'($urandom);
   endfunction

   initial begin
      byte_type enc_bytes[5];
      codec_sb                = new();
      calm                    = 1'b0;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.operation     <= OP_ENCODE;
      req_chan.data_in       <= '0;
      req_chan.code_low_in   <= '0;
      req_chan.code_high_in  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: encode extremes, every single-bit error, double errors, raw words
      enc_bytes = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'hA5};
      foreach (enc_bytes[i])
         send_word(OP_ENCODE, enc_bytes[i], 8'hFF, 8'h00);
      send_word(OP_DECODE, 8'hFF, codeword_of(4'h6), codeword_of(4'h9));
      for (int b = 0; b < 8; b++)
         send_word(OP_DECODE, 8'h00, codeword_of(4'h6) ^ (8'h01 << b),
                   codeword_of(4'h9) ^ (8'h80 >> b));
      send_word(OP_DECODE, 8'h55, codeword_of(4'h3) ^ 8'h28, codeword_of(4'hC) ^ 8'h06);
      send_word(OP_DECODE, 8'hAA, codeword_of(4'hF) ^ 8'hC0, codeword_of(4'h0) ^ 8'h12);
      send_word(OP_DECODE, 8'h00, 8'h00, 8'hFF);
      send_word(OP_DECODE, 8'hFF, 8'hFF, 8'h00);
      drain();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm = (i >= 500 && i < 800);
         if (i == 900)
            drain();
         if ($urandom_range(9) < 3)
            send_word(OP_ENCODE, byte_type'($urandom), byte_type'($urandom),
                      byte_type'($urandom));
         else
            send_word(OP_DECODE, byte_type'($urandom),
                      damaged_codeword(nibble_type'($urandom)),
                      damaged_codeword(nibble_type'($urandom)));
      end
      calm = 1'b0;

      drain();
      repeat (5) @(posedge clock);
      if (codec_sb.errors == 0 && codec_sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
design/hnbc_pkg.sv
design/hnbc_if.sv
design/hnbc_lane.sv
design/hnbc_merge.sv
design/hamming_nibble_byte_codec_core.sv
tb/hnbc_scoreboard_pkg.sv
tb/hamming_nibble_byte_codec_core_test.sv
